>>> hw/rtl/ear_pkg.sv
`timescale 1ns / 1ps
package ear_pkg;

    // Fraction bits kept by each distance.
    localparam int DIST_FRAC  = 8;
    // Width of the ratio result.
    localparam int RATIO_BITS = 16;
    // Number of distances per eye.
    localparam int NUM_DIST   = 3;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

    // Fill state of the queue between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> hw/rtl/ear_front.sv
`timescale 1ns / 1ps
module ear_front
    import ear_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [COORD_BITS-1:0]       i_outer_corner_x,
    input  logic [COORD_BITS-1:0]       i_outer_corner_y,
    input  logic [COORD_BITS-1:0]       i_upper_outer_x,
    input  logic [COORD_BITS-1:0]       i_upper_outer_y,
    input  logic [COORD_BITS-1:0]       i_upper_inner_x,
    input  logic [COORD_BITS-1:0]       i_upper_inner_y,
    input  logic [COORD_BITS-1:0]       i_inner_corner_x,
    input  logic [COORD_BITS-1:0]       i_inner_corner_y,
    input  logic [COORD_BITS-1:0]       i_lower_inner_x,
    input  logic [COORD_BITS-1:0]       i_lower_inner_y,
    input  logic [COORD_BITS-1:0]       i_lower_outer_x,
    input  logic [COORD_BITS-1:0]       i_lower_outer_y,
    input  t_q_stat                     i_q_stat,
    output logic                        o_push,
    output logic [6*COORD_BITS-1:0]     o_push_data
);

    logic                    r_valid;
    logic [6*COORD_BITS-1:0] r_diff;
    logic [6*COORD_BITS-1:0] n_diff;

    function automatic logic [COORD_BITS-1:0] absdiff(
        input logic [COORD_BITS-1:0] p,
        input logic [COORD_BITS-1:0] q
    );
        absdiff = (p >= q) ? (p - q) : (q - p);
    endfunction

    // Packed as {c_dy, c_dx, b_dy, b_dx, a_dy, a_dx}.
    always_comb begin
        n_diff = {absdiff(i_outer_corner_y, i_inner_corner_y),
                  absdiff(i_outer_corner_x, i_inner_corner_x),
                  absdiff(i_upper_inner_y, i_lower_inner_y),
                  absdiff(i_upper_inner_x, i_lower_inner_x),
                  absdiff(i_upper_outer_y, i_lower_outer_y),
                  absdiff(i_upper_outer_x, i_lower_outer_x)};
    end

    assign o_push      = r_valid && !i_q_stat.full;
    assign o_ready     = !r_valid || !i_q_stat.full;
    assign o_push_data = r_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_diff <= n_diff;
        end
    end

endmodule

>>> hw/rtl/ear_queue.sv
`timescale 1ns / 1ps
module ear_queue
    import ear_pkg::*;
#(
    parameter int DATA_BITS = 72
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    input  logic                 i_pop,
    output logic [DATA_BITS-1:0] o_data,
    output t_q_stat              o_stat
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [AW-1:0]        r_wptr;
    logic [AW-1:0]        r_rptr;
    logic [AW:0]          r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_stat.full  = (r_count == (AW+1)'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

>>> hw/rtl/ear_back.sv
`timescale 1ns / 1ps
module ear_back
    import ear_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_q_stat                 i_q_stat,
    input  logic [6*COORD_BITS-1:0] i_data,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [RATIO_BITS-1:0]   o_ratio_value,
    output logic [1:0]              o_ratio_status
);

    // Radicand is (dx^2 + dy^2) scaled by 2^(2*DIST_FRAC).
    localparam int SQ_W  = 2*COORD_BITS + 1;
    localparam int RAD_W = SQ_W + 2*DIST_FRAC;
    localparam int K     = (RAD_W + 1) / 2;      // root bits = sqrt steps
    localparam int RW2   = 2*K;
    localparam int REM_W = K + 2;
    localparam int SUM_W = K + 1;
    localparam int NW    = SUM_W + FRAC_BITS;    // dividend width
    localparam int CW    = NW + RATIO_BITS + 2;  // compare width
    localparam int NV    = K + 2 + RATIO_BITS;   // total stages

    logic            r_v [NV];
    logic            en;

    logic [RW2-1:0]   r_rad  [NUM_DIST][K+1];
    logic [REM_W-1:0] r_rem  [NUM_DIST][K+1];
    logic [K-1:0]     r_root [NUM_DIST][K+1];
    logic [RW2-1:0]   n_rad  [NUM_DIST][K+1];
    logic [REM_W-1:0] n_rem  [NUM_DIST][K+1];
    logic [K-1:0]     n_root [NUM_DIST][K+1];

    logic [NW-1:0]          r_drem [RATIO_BITS+1];
    logic [SUM_W-1:0]       r_div  [RATIO_BITS+1];
    logic [RATIO_BITS-1:0]  r_q    [RATIO_BITS+1];
    t_status                r_st   [RATIO_BITS+1];
    logic [NW-1:0]          n_drem [RATIO_BITS+1];
    logic [RATIO_BITS-1:0]  n_q    [RATIO_BITS+1];

    logic [SUM_W-1:0]  p_sum;
    logic [SUM_W-1:0]  p_div;
    logic              p_sat;

    assign en             = !r_v[NV-1] || i_ready;
    assign o_pop          = en && !i_q_stat.empty;
    assign o_valid        = r_v[NV-1];
    assign o_ratio_value  = r_q[RATIO_BITS];
    assign o_ratio_status = r_st[RATIO_BITS];

    // Squares of the differences seed the radicands. Each later stage takes
    // one restoring square-root step, two radicand bits at a time.
    always_comb begin
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic [SQ_W-1:0]       sq;
        logic [REM_W+1:0]      t;
        logic [REM_W+1:0]      trial;
        for (int d = 0; d < NUM_DIST; d++) begin
            dx = i_data[(2*d)*COORD_BITS +: COORD_BITS];
            dy = i_data[(2*d+1)*COORD_BITS +: COORD_BITS];
            sq = SQ_W'(dx) * SQ_W'(dx) + SQ_W'(dy) * SQ_W'(dy);
            n_rad[d][0]  = RW2'(sq) << (2*DIST_FRAC);
            n_rem[d][0]  = '0;
            n_root[d][0] = '0;
            for (int j = 1; j <= K; j++) begin
                t     = {r_rem[d][j-1], r_rad[d][j-1][RW2-1 -: 2]};
                trial = (REM_W+2)'({r_root[d][j-1], 2'b01});
                n_rad[d][j] = r_rad[d][j-1] << 2;
                if (t >= trial) begin
                    n_rem[d][j]  = REM_W'(t - trial);
                    n_root[d][j] = {r_root[d][j-1][K-2:0], 1'b1};
                end else begin
                    n_rem[d][j]  = REM_W'(t);
                    n_root[d][j] = {r_root[d][j-1][K-2:0], 1'b0};
                end
            end
        end
    end

    // Divide setup: sum the lid distances, double the corner distance,
    // and settle the saturated and zero-width cases up front.
    always_comb begin
        p_sum = SUM_W'(r_root[0][K]) + SUM_W'(r_root[1][K]);
        p_div = {r_root[2][K], 1'b0};
        p_sat = (CW'(p_sum) << FRAC_BITS) >= (CW'(p_div) << RATIO_BITS);
    end

    // One quotient bit per stage, most significant first.
    always_comb begin
        logic [CW-1:0] sh;
        n_drem[0] = '0;
        n_q[0]    = '0;
        for (int t = 1; t <= RATIO_BITS; t++) begin
            sh        = CW'(r_div[t-1]) << (RATIO_BITS - t);
            n_drem[t] = r_drem[t-1];
            n_q[t]    = r_q[t-1];
            if (r_st[t-1] == ST_OK && CW'(r_drem[t-1]) >= sh) begin
                n_drem[t] = NW'(CW'(r_drem[t-1]) - sh);
                n_q[t][RATIO_BITS - t] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NV; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= !i_q_stat.empty;
            for (int s = 1; s < NV; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int d = 0; d < NUM_DIST; d++) begin
                for (int j = 0; j <= K; j++) begin
                    r_rad[d][j]  <= n_rad[d][j];
                    r_rem[d][j]  <= n_rem[d][j];
                    r_root[d][j] <= n_root[d][j];
                end
            end
            r_drem[0] <= NW'(p_sum) << FRAC_BITS;
            r_div[0]  <= p_div;
            if (r_root[2][K] == '0) begin
                r_st[0] <= ST_ZERO;
                r_q[0]  <= '0;
            end else if (p_sat) begin
                r_st[0] <= ST_SAT;
                r_q[0]  <= '1;
            end else begin
                r_st[0] <= ST_OK;
                r_q[0]  <= '0;
            end
            for (int t = 1; t <= RATIO_BITS; t++) begin
                r_drem[t] <= n_drem[t];
                r_div[t]  <= r_div[t-1];
                r_q[t]    <= n_q[t];
                r_st[t]   <= r_st[t-1];
            end
        end
    end

`ifndef SYNTH
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ratio_status == ST_ZERO) |-> (o_ratio_value == '0))
        else $error("zero-width result carries a nonzero value");
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ratio_status == ST_SAT) |-> (o_ratio_value == '1))
        else $error("saturated result is not at maximum");
    a_no_code3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ratio_status != 2'd3))
        else $error("undefined status code");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_ratio_value)))
        else $error("output changed during stall");
`endif

endmodule

>>> hw/rtl/eye_aspect_ratio_unit.sv
`timescale 1ns / 1ps
// Eye aspect ratio unit. One input item carries the six landmarks of one
// eye; one result item returns (a + b) / (2c) as unsigned Q4.12 plus a
// status code (ok, saturated, zero corner distance).
// Both channels use valid/ready; an item moves when valid and ready are high.
// A front stage registers the coordinate differences and pushes them into
// a four-entry queue. The back pipeline squares them, takes three square
// roots with one root bit per stage, and divides with one quotient bit per
// stage. Throughput is one item per clock cycle while the receiver keeps
// ready high, set by the fully pipelined square-root and divider stages.
// When the receiver stalls, the whole back pipeline holds and the result
// stays on the output; the queue keeps absorbing items until it is full,
// and only then does input ready drop.
// Reset clears all valid flags and queue pointers; no item is in flight
// afterward and the unit accepts input in the first cycle after reset.
module eye_aspect_ratio_unit
    import ear_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_BITS-1:0] i_outer_corner_x,
    input  logic [COORD_BITS-1:0] i_outer_corner_y,
    input  logic [COORD_BITS-1:0] i_upper_outer_x,
    input  logic [COORD_BITS-1:0] i_upper_outer_y,
    input  logic [COORD_BITS-1:0] i_upper_inner_x,
    input  logic [COORD_BITS-1:0] i_upper_inner_y,
    input  logic [COORD_BITS-1:0] i_inner_corner_x,
    input  logic [COORD_BITS-1:0] i_inner_corner_y,
    input  logic [COORD_BITS-1:0] i_lower_inner_x,
    input  logic [COORD_BITS-1:0] i_lower_inner_y,
    input  logic [COORD_BITS-1:0] i_lower_outer_x,
    input  logic [COORD_BITS-1:0] i_lower_outer_y,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [15:0]           o_ratio_value,
    output logic [1:0]            o_ratio_status
);

    logic                    push;
    logic                    pop;
    logic [6*COORD_BITS-1:0] push_data;
    logic [6*COORD_BITS-1:0] pop_data;
    t_q_stat                 q_stat;

    // Front: registers the absolute coordinate differences.
    ear_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_outer_corner_x (i_outer_corner_x),
        .i_outer_corner_y (i_outer_corner_y),
        .i_upper_outer_x  (i_upper_outer_x),
        .i_upper_outer_y  (i_upper_outer_y),
        .i_upper_inner_x  (i_upper_inner_x),
        .i_upper_inner_y  (i_upper_inner_y),
        .i_inner_corner_x (i_inner_corner_x),
        .i_inner_corner_y (i_inner_corner_y),
        .i_lower_inner_x  (i_lower_inner_x),
        .i_lower_inner_y  (i_lower_inner_y),
        .i_lower_outer_x  (i_lower_outer_x),
        .i_lower_outer_y  (i_lower_outer_y),
        .i_q_stat         (q_stat),
        .o_push           (push),
        .o_push_data      (push_data)
    );

    // Queue decouples the front from stalls in the back.
    ear_queue #(.DATA_BITS(6*COORD_BITS)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_stat  (q_stat)
    );

    // Back: square roots, divide, saturation and the output register.
    ear_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_stat       (q_stat),
        .i_data         (pop_data),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_ratio_value  (o_ratio_value),
        .o_ratio_status (o_ratio_status)
    );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import ear_pkg::*;

    localparam int CB = 12;
    localparam int FB = 12;
    localparam int LATENCY = 60;

    // One eye: six landmarks in the order outer corner, upper outer, upper inner,
    // inner corner, lower inner, lower outer, each as an x and a y.
    typedef struct {
        logic [CB-1:0] x[6];
        logic [CB-1:0] y[6];
    } t_eye;

    typedef struct {
        logic [15:0] value;
        t_status     status;
    } t_ratio;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [CB-1:0] pt_x[6];
    logic [CB-1:0] pt_y[6];
    logic o_valid;
    logic i_ready = 1'b0;
    logic [15:0] o_ratio_value;
    logic [1:0] o_ratio_status;

    t_ratio expected_ratios[$];
    int mismatches = 0;
    int results_seen = 0;
    int items_sent = 0;
    int idle_pct = 34;
    int hold_off = 0;

    initial begin
        for (int k = 0; k < 6; k++) begin
            pt_x[k] = '0;
            pt_y[k] = '0;
        end
    end

    always #1 i_clk = ~i_clk;

    eye_aspect_ratio_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_outer_corner_x(pt_x[0]), .i_outer_corner_y(pt_y[0]),
        .i_upper_outer_x(pt_x[1]),  .i_upper_outer_y(pt_y[1]),
        .i_upper_inner_x(pt_x[2]),  .i_upper_inner_y(pt_y[2]),
        .i_inner_corner_x(pt_x[3]), .i_inner_corner_y(pt_y[3]),
        .i_lower_inner_x(pt_x[4]),  .i_lower_inner_y(pt_y[4]),
        .i_lower_outer_x(pt_x[5]),  .i_lower_outer_y(pt_y[5]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_ratio_value(o_ratio_value), .o_ratio_status(o_ratio_status)
    );

    // Floor square root, bit by bit.
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Distance with DIST_FRAC fraction bits.
    function automatic longint unsigned landmark_dist(logic [CB-1:0] x0, logic [CB-1:0] y0,
                                                      logic [CB-1:0] x1, logic [CB-1:0] y1);
        longint unsigned dx;
        longint unsigned dy;
        dx = (x0 >= x1) ? x0 - x1 : x1 - x0;
        dy = (y0 >= y1) ? y0 - y1 : y1 - y0;
        return floor_sqrt((dx * dx + dy * dy) << (2 * DIST_FRAC));
    endfunction

    function automatic t_ratio eye_ratio(t_eye e);
        longint unsigned a;
        longint unsigned b;
        longint unsigned c;
        longint unsigned q;
        t_ratio r;
        a = landmark_dist(e.x[1], e.y[1], e.x[5], e.y[5]);
        b = landmark_dist(e.x[2], e.y[2], e.x[4], e.y[4]);
        c = landmark_dist(e.x[0], e.y[0], e.x[3], e.y[3]);
        if (c == 0) begin
            r.value = '0;
            r.status = ST_ZERO;
        end else begin
            q = ((a + b) << FB) / (c << 1);
            if (q > 65535) begin
                r.value = 16'hFFFF;
                r.status = ST_SAT;
            end else begin
                r.value = q[15:0];
                r.status = ST_OK;
            end
        end
        return r;
    endfunction

    // Sends one eye; the expectation is queued when the handshake completes.
    // Valid stays high after the handshake until the next item or an idle cycle.
    task automatic send_eye(t_eye e);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        for (int k = 0; k < 6; k++) begin
            pt_x[k] <= e.x[k];
            pt_y[k] <= e.y[k];
        end
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_ratios = {expected_ratios, eye_ratio(e)};
        items_sent++;
    endtask

    function automatic t_eye random_eye();
        t_eye e;
        int mode;
        int cx;
        int cy;
        mode = $urandom_range(9);
        cx = $urandom_range(4095);
        cy = $urandom_range(4095);
        for (int k = 0; k < 6; k++) begin
            if (mode < 6) begin
                // A plausible eye: points clustered around one center.
                e.x[k] = CB'((cx + $urandom_range(120) - 60) & 12'hFFF);
                e.y[k] = CB'((cy + $urandom_range(60) - 30) & 12'hFFF);
            end else if (mode < 8) begin
                e.x[k] = CB'($urandom);
                e.y[k] = CB'($urandom);
            end else begin
                e.x[k] = CB'(cx + $urandom_range(3));
                e.y[k] = CB'(cy + $urandom_range(3));
            end
        end
        if ($urandom_range(19) == 0) begin
            e.x[3] = e.x[0];
            e.y[3] = e.y[0];
        end
        return e;
    endfunction

    // The receiver idles at random, or holds off entirely for a counted stretch.
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            i_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_ratio want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_ratios.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h/%0d",
                                               o_ratio_value, o_ratio_status);
            end else begin
                want = expected_ratios.pop_front();
                if (o_ratio_value !== want.value || o_ratio_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%0d got %h/%0d", want.value,
                                 want.status, o_ratio_value, o_ratio_status);
                end
            end
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_ratios.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_eye e;
        for (int k = 0; k < 6; k++) begin
            e.x[k] = '0;
            e.y[k] = '0;
        end
        send_eye(e);                        // all coincide: zero width
        for (int k = 0; k < 6; k++) begin
            e.x[k] = '1;
            e.y[k] = '1;
        end
        send_eye(e);
        e.x[3] = '0;                        // wide, flat eye
        send_eye(e);
        e.x = '{0, 0, 1, 1, 1, 0};          // narrow corners, tall lids: saturation
        e.y = '{0, 0, 0, 0, 4095, 4095};
        send_eye(e);
        e.x = '{0, 4095, 0, 4095, 4095, 0};
        e.y = '{4095, 0, 4095, 0, 0, 4095};
        send_eye(e);
        e.x = '{100, 110, 120, 130, 120, 110};
        e.y = '{200, 195, 195, 200, 205, 205};
        send_eye(e);
        e.x = '{12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555};
        e.y = '{12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA};
        send_eye(e);
        e.x = '{0, 5, 5, 1, 5, 5};          // one pixel corner distance
        e.y = '{0, 0, 0, 0, 1, 1};
        send_eye(e);
    endtask

    task automatic test_random(int count);
        repeat (count) send_eye(random_eye());
    endtask

    // Receiver holds off while the sender keeps going until the queue stalls it.
    task automatic test_backpressure();
        hold_off <= 200;
        test_random(60);
        wait_drained();
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_streaming();
        idle_pct = 0;
        test_random(200);
        idle_pct = 34;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        test_random(300);
        test_backpressure();
        test_streaming();
        test_random(330);
        wait_drained();
        repeat (LATENCY) @(posedge i_clk);
        $display("Covered %0d eyes, %0d results: extremes, zero width, saturation,", items_sent,
                 results_seen);
        $display("random landmarks, a long receiver stall and unthrottled streaming.");
        if (mismatches == 0 && expected_ratios.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ear_pkg.sv
hw/rtl/ear_front.sv
hw/rtl/ear_queue.sv
hw/rtl/ear_back.sv
hw/rtl/eye_aspect_ratio_unit.sv
bench/tb.sv
